@@ sv/bmss_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Boyer-Moore substring search block.
// Holds the sequencer state type, operation codes and fixed field widths; no dependencies.
package bmss_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 12;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BC_FILL,
		ST_BC_RD,
		ST_BC_WR,
		ST_GS_CHK,
		ST_GS_CMP,
		ST_SR_CHK,
		ST_SR_CMP,
		ST_SR_SHIFT
	} bmss_state_t;

endpackage

@@ sv/bmss_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for every store of the search block.
module bmss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/boyer_moore_substring_search_top.sv @@
`timescale 1ns / 1ps
// Top level of the Boyer-Moore substring search block: loader, table builder and search.
// Depends on bmss_pkg and bmss_ram.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------
//  request   start && !busy       operation, byte_value, last
//  result    strobe (one cycle)   found, position, overflow
//
// A pattern or text byte comes with each accepted request. When a pattern closes, the
// bad-character table is first filled with the pattern length in every entry, then
// each pattern byte but the last is read and written back as its distance from the
// end, and the good-suffix table is built by a compare loop over pairs of pattern
// bytes. The search reads one text byte and one pattern byte per compare and adds a
// shift after each mismatch, using the single pattern RAM read port in each step.
// busy is high for all of that time. The reset is asynchronous and leaves
// an empty, closed pattern, so a text alone matches at offset 0. The receiver
// cannot stall: the result is shown for exactly one cycle with strobe high.
module boyer_moore_substring_search_top #(
	parameter int MAX_PATTERN = 64,
	parameter int MAX_TEXT    = 4096,
	parameter int ALPHABET    = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [bmss_pkg::BYTE_W-1:0] byte_value,
	input  logic                        last,
	output logic                        strobe,
	output logic                        found,
	output logic [bmss_pkg::POS_W-1:0]  position,
	output logic                        overflow
);

	import bmss_pkg::*;

	// Widths that follow from the capacities.
	localparam int PW  = $clog2(MAX_PATTERN + 1);          // pattern length and indexes
	localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int GAW = $clog2(MAX_PATTERN + 1);          // good-suffix table address
	localparam int GW  = (MAX_PATTERN > 1) ? $clog2(2 * MAX_PATTERN) : 1;
	localparam int BAW = $clog2(ALPHABET);
	localparam int TW  = $clog2(MAX_TEXT + 1);
	localparam int TAW = $clog2(MAX_TEXT);
	localparam int JW  = $clog2(MAX_TEXT + 2 * MAX_PATTERN + 1);

	bmss_state_t state_q, state_d;

	// Loader state.
	logic [PW-1:0] plen_q;
	logic          closed_q;
	logic          pdrop_q;
	logic [TW-1:0] tlen_q;
	logic          tdrop_q;
	logic          search_pend_q;

	// Table build counters.
	logic [BAW-1:0] fc_q;
	logic [PW-1:0]  bi_q;
	logic [PW-1:0]  gj_q, gs_q, gk_q;

	// Search pointers, both kept one above the model's indexes so they stay unsigned.
	logic [PW-1:0]     ip1_q;
	logic [JW-1:0]     jp1_q;
	logic [BYTE_W-1:0] c_q;

	logic              strobe_q, found_q, overflow_q;
	logic [POS_W-1:0]  position_q;

	// RAM ports.
	logic              p_we;
	logic [PAW-1:0]    p_waddr, pa_raddr, pb_raddr;
	logic [BYTE_W-1:0] pa_q, pb_q;
	logic              t_we;
	logic [TAW-1:0]    t_raddr;
	logic [BYTE_W-1:0] t_q;
	logic              bc_we;
	logic [BAW-1:0]    bc_waddr, bc_raddr;
	logic [PW-1:0]     bc_wdata, bc_q;
	logic              gs_we;
	logic [GW-1:0]     gs_wdata, gs_rq;

	// Request decode.
	logic          accept;
	logic [PW-1:0] peff;
	logic          p_room, t_room;

	// Good-suffix step decode.
	logic          gs_need_rd, gs_pass_cmp, gs_at_end;
	// Search decode.
	logic          sr_hit, sr_out;
	logic [JW-1:0] jm1, shift_amt, bcv_ext, gsv_ext;
	logic          pa_in_alpha, c_in_alpha;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign peff    = closed_q ? '0 : plen_q;
	assign p_room  = (peff < PW'(MAX_PATTERN));
	assign t_room  = (tlen_q < TW'(MAX_TEXT));

	assign p_we    = accept && (operation == OP_PATTERN) && p_room;
	assign p_waddr = peff[PAW-1:0];
	assign t_we    = accept && (operation == OP_TEXT) && t_room;

	// For k equal to j the pair must differ; for a longer suffix it must agree.
	assign gs_need_rd  = (gk_q == gj_q) ? (gs_q < gj_q) : (gs_q < gk_q);
	assign gs_pass_cmp = (gk_q == gj_q) ? (pa_q != pb_q) : (pa_q == pb_q);
	assign gs_at_end   = (gk_q == plen_q);
	assign gs_wdata    = GW'(({1'b0, gs_q} + {1'b0, plen_q}) - {1'b0, gj_q});

	assign pa_in_alpha = ({1'b0, pa_q} < 9'(ALPHABET));
	assign c_in_alpha  = ({1'b0, c_q} < 9'(ALPHABET));

	assign sr_hit    = (ip1_q == '0);
	assign sr_out    = (jp1_q > JW'(tlen_q));
	assign jm1       = jp1_q - JW'(1);
	assign t_raddr   = jm1[TAW-1:0];
	assign bc_raddr  = t_q[BAW-1:0];
	assign bcv_ext   = c_in_alpha ? JW'(bc_q) : '0;
	assign gsv_ext   = JW'(gs_rq);
	assign shift_amt = (gsv_ext > bcv_ext) ? gsv_ext : bcv_ext;

	always_comb begin
		pb_raddr = PAW'(gk_q - PW'(1));
		unique case (state_q)
			ST_BC_RD:  pa_raddr = bi_q[PAW-1:0];
			ST_GS_CHK: pa_raddr = PAW'(gk_q - gs_q - PW'(1));
			ST_SR_CHK: pa_raddr = PAW'(ip1_q - PW'(1));
			default:   pa_raddr = '0;
		endcase
	end

	always_comb begin
		bc_we    = 1'b0;
		bc_waddr = fc_q;
		bc_wdata = plen_q;
		if (state_q == ST_BC_FILL) begin
			bc_we = 1'b1;
		end else if (state_q == ST_BC_WR) begin
			bc_we    = pa_in_alpha;
			bc_waddr = pa_q[BAW-1:0];
			bc_wdata = plen_q - PW'(1) - bi_q;
		end
	end

	always_comb begin
		gs_we = 1'b0;
		if (state_q == ST_GS_CHK && !gs_need_rd && gs_at_end) begin
			gs_we = 1'b1;
		end else if (state_q == ST_GS_CMP && gs_pass_cmp && gs_at_end) begin
			gs_we = 1'b1;
		end
	end

	bmss_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_a (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(byte_value),
		.raddr(pa_raddr), .rdata(pa_q)
	);

	// Second copy of the pattern so the good-suffix check reads two bytes at once.
	bmss_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pat_b (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(byte_value),
		.raddr(pb_raddr), .rdata(pb_q)
	);

	bmss_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_TEXT)) u_text (
		.clk(clk), .we(t_we), .waddr(tlen_q[TAW-1:0]), .wdata(byte_value),
		.raddr(t_raddr), .rdata(t_q)
	);

	bmss_ram #(.WIDTH(PW), .DEPTH(ALPHABET)) u_bad_char (
		.clk(clk), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
		.raddr(bc_raddr), .rdata(bc_q)
	);

	bmss_ram #(.WIDTH(GW), .DEPTH(MAX_PATTERN + 1)) u_good_suffix (
		.clk(clk), .we(gs_we), .waddr(gj_q[GAW-1:0]), .wdata(gs_wdata),
		.raddr(ip1_q[GAW-1:0]), .rdata(gs_rq)
	);

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && last) begin
					if (operation == OP_PATTERN || !closed_q) begin
						state_d = ST_BC_FILL;
					end else begin
						state_d = ST_SR_CHK;
					end
				end
			end
			ST_BC_FILL: begin
				if (fc_q == BAW'(ALPHABET - 1)) begin
					state_d = (plen_q > PW'(1)) ? ST_BC_RD : ST_GS_CHK;
				end
			end
			ST_BC_RD: state_d = ST_BC_WR;
			ST_BC_WR: begin
				state_d = (bi_q == plen_q - PW'(2)) ? ST_GS_CHK : ST_BC_RD;
			end
			ST_GS_CHK: begin
				if (gs_need_rd) begin
					state_d = ST_GS_CMP;
				end else if (gs_at_end && gj_q == plen_q) begin
					state_d = search_pend_q ? ST_SR_CHK : ST_IDLE;
				end
			end
			ST_GS_CMP: begin
				if (gs_pass_cmp && gs_at_end && gj_q == plen_q) begin
					state_d = search_pend_q ? ST_SR_CHK : ST_IDLE;
				end else begin
					state_d = ST_GS_CHK;
				end
			end
			ST_SR_CHK: begin
				state_d = (sr_hit || sr_out) ? ST_IDLE : ST_SR_CMP;
			end
			ST_SR_CMP: begin
				state_d = (t_q == pa_q) ? ST_SR_CHK : ST_SR_SHIFT;
			end
			ST_SR_SHIFT: state_d = ST_SR_CHK;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loader, counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q        <= '0;
			closed_q      <= 1'b1;
			pdrop_q       <= 1'b0;
			tlen_q        <= '0;
			tdrop_q       <= 1'b0;
			search_pend_q <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_PATTERN) begin
							if (closed_q) begin
								pdrop_q <= 1'b0;
							end
							closed_q <= 1'b0;
							if (p_room) begin
								plen_q <= peff + PW'(1);
							end else begin
								pdrop_q <= 1'b1;
							end
							search_pend_q <= 1'b0;
						end else begin
							if (t_room) begin
								tlen_q <= tlen_q + TW'(1);
							end else begin
								tdrop_q <= 1'b1;
							end
							search_pend_q <= last;
						end
						fc_q  <= '0;
						bi_q  <= '0;
						gj_q  <= PW'(1);
						gs_q  <= PW'(1);
						gk_q  <= PW'(1);
						ip1_q <= plen_q;
						jp1_q <= JW'(plen_q);
					end
				end
				ST_BC_FILL: begin
					fc_q <= fc_q + BAW'(1);
				end
				ST_BC_RD: begin
				end
				ST_BC_WR: begin
					bi_q <= bi_q + PW'(1);
				end
				ST_GS_CHK: begin
					if (!gs_need_rd) begin
						if (gs_at_end) begin
							gj_q <= gj_q + PW'(1);
							gs_q <= PW'(1);
							gk_q <= gj_q + PW'(1);
						end else begin
							gk_q <= gk_q + PW'(1);
						end
					end
				end
				ST_GS_CMP: begin
					if (!gs_pass_cmp) begin
						gs_q <= gs_q + PW'(1);
						gk_q <= gj_q;
					end else if (gs_at_end) begin
						gj_q <= gj_q + PW'(1);
						gs_q <= PW'(1);
						gk_q <= gj_q + PW'(1);
					end else begin
						gk_q <= gk_q + PW'(1);
					end
				end
				ST_SR_CHK: begin
					// The pattern closes once the tables are built.
					closed_q <= 1'b1;
					if (sr_hit || sr_out) begin
						strobe_q      <= 1'b1;
						found_q       <= sr_hit;
						position_q    <= sr_hit ? POS_W'(jp1_q) : '0;
						overflow_q    <= pdrop_q | tdrop_q;
						tlen_q        <= '0;
						tdrop_q       <= 1'b0;
						search_pend_q <= 1'b0;
					end
				end
				ST_SR_CMP: begin
					if (t_q == pa_q) begin
						ip1_q <= ip1_q - PW'(1);
						jp1_q <= jm1;
					end else begin
						c_q <= t_q;
					end
				end
				ST_SR_SHIFT: begin
					jp1_q <= jp1_q + shift_amt;
					ip1_q <= plen_q;
				end
				default: begin
				end
			endcase
			// A build that does not run into a search still closes the pattern.
			if (state_d == ST_IDLE && (state_q == ST_GS_CHK || state_q == ST_GS_CMP)) begin
				closed_q <= 1'b1;
			end
		end
	end

	assign strobe   = strobe_q;
	assign found    = found_q;
	assign position = position_q;
	assign overflow = overflow_q;

endmodule
